// File: sv/button_click_classifier_defines.svh
// Assertion macros shared by the button click classifier RTL.
`ifndef BUTTON_CLICK_CLASSIFIER_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BCC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

// Next-cycle implication, disabled while in reset.
`define BCC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`endif

// File: sv/bcc_pkg.sv
// Types and constants for the button click classifier.
`default_nettype none
package bcc_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PRESS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PRESS     = 2'd2;

    localparam logic [CFG_W-1:0] RELEASE_LIMIT_RST = 16'd3000;
    localparam logic [CFG_W-1:0] MIN_PRESS_RST     = 16'd200;
    localparam logic [CFG_W-1:0] MAX_PRESS_RST     = 16'd10000;

    localparam logic [1:0] CLICKS_NONE = 2'd0;
    localparam logic [1:0] CLICKS_ONE  = 2'd1;
    localparam logic [1:0] CLICKS_TWO  = 2'd2;
    localparam logic [1:0] CLICKS_MAX  = 2'd3;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_code_t;

    typedef struct packed {
        logic [CFG_W-1:0] release_limit;
        logic [CFG_W-1:0] min_press;
        logic [CFG_W-1:0] max_press;
    } cfg_t;

endpackage
`default_nettype wire

// File: sv/bcc_cfg_regs.sv
// Configuration register file for the button click classifier.
`default_nettype none
module bcc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           wr_en,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [bcc_pkg::CFG_W-1:0]      wr_data,
    output bcc_pkg::cfg_t                       cfg
);

    bcc_pkg::cfg_t cfg_reg;
    bcc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                bcc_pkg::REG_RELEASE_LIMIT: cfg_next.release_limit = wr_data;
                bcc_pkg::REG_MIN_PRESS:     cfg_next.min_press     = wr_data;
                bcc_pkg::REG_MAX_PRESS:     cfg_next.max_press     = wr_data;
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.release_limit <= bcc_pkg::RELEASE_LIMIT_RST;
            cfg_reg.min_press     <= bcc_pkg::MIN_PRESS_RST;
            cfg_reg.max_press     <= bcc_pkg::MAX_PRESS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// File: sv/bcc_core.sv
// Per-tick click classification state and event decode.
`default_nettype none
`include "button_click_classifier_defines.svh"
module bcc_core #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          beat_en,
    input  wire logic          level,
    input  wire bcc_pkg::cfg_t cfg,
    output bcc_pkg::event_code_t event_code
);

    localparam int CMP_W = (TIMER_BITS > bcc_pkg::CFG_W) ? TIMER_BITS : bcc_pkg::CFG_W;

    logic                  prior_level_reg, prior_level_next;
    logic [TIMER_BITS-1:0] elapsed_ticks_reg, elapsed_ticks_next;
    logic [TIMER_BITS-1:0] held_ticks_reg, held_ticks_next;
    logic [TIMER_BITS-1:0] released_ticks_reg, released_ticks_next;
    logic [1:0]            click_count_reg, click_count_next;

    logic                  level_edge;
    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      inc_x, held_x, released_x;
    logic [CMP_W-1:0]      rel_lim_x, min_x, max_x;
    logic                  click_ok;

    assign level_edge  = level != prior_level_reg;
    assign elapsed_inc = (&elapsed_ticks_reg) ? elapsed_ticks_reg
                                              : elapsed_ticks_reg + TIMER_BITS'(1);
    assign inc_x      = CMP_W'(elapsed_inc);
    assign held_x     = CMP_W'(held_ticks_reg);
    assign released_x = CMP_W'(released_ticks_reg);
    assign rel_lim_x  = CMP_W'(cfg.release_limit);
    assign min_x      = CMP_W'(cfg.min_press);
    assign max_x      = CMP_W'(cfg.max_press);
    assign click_ok   = (held_x > min_x) && (held_x < max_x);

    always_comb begin
        prior_level_next    = prior_level_reg;
        elapsed_ticks_next  = elapsed_ticks_reg;
        held_ticks_next     = held_ticks_reg;
        released_ticks_next = released_ticks_reg;
        click_count_next    = click_count_reg;
        event_code          = bcc_pkg::EV_NONE;
        if (level_edge) begin
            prior_level_next   = level;
            elapsed_ticks_next = '0;
            if (!level) begin
                if (released_x > rel_lim_x) begin
                    click_count_next = bcc_pkg::CLICKS_NONE;
                end
            end else if ((click_ok || click_count_reg == bcc_pkg::CLICKS_ONE)
                         && click_count_reg != bcc_pkg::CLICKS_MAX) begin
                click_count_next = click_count_reg + 2'd1;
            end
        end else begin
            elapsed_ticks_next = elapsed_inc;
            if (!level) begin
                held_ticks_next = elapsed_inc;
                if (inc_x > max_x && click_count_reg == bcc_pkg::CLICKS_NONE) begin
                    elapsed_ticks_next = '0;
                    event_code         = bcc_pkg::EV_LONG;
                end
            end else begin
                released_ticks_next = elapsed_inc;
                if (click_count_reg == bcc_pkg::CLICKS_ONE && inc_x > rel_lim_x) begin
                    elapsed_ticks_next = '0;
                    click_count_next   = bcc_pkg::CLICKS_NONE;
                    event_code         = bcc_pkg::EV_SINGLE;
                end else if (click_count_reg == bcc_pkg::CLICKS_TWO) begin
                    elapsed_ticks_next = '0;
                    click_count_next   = bcc_pkg::CLICKS_NONE;
                    event_code         = bcc_pkg::EV_DOUBLE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prior_level_reg    <= 1'b1;
            elapsed_ticks_reg  <= '0;
            held_ticks_reg     <= '0;
            released_ticks_reg <= '0;
            click_count_reg    <= bcc_pkg::CLICKS_NONE;
        end else if (beat_en) begin
            prior_level_reg    <= prior_level_next;
            elapsed_ticks_reg  <= elapsed_ticks_next;
            held_ticks_reg     <= held_ticks_next;
            released_ticks_reg <= released_ticks_next;
            click_count_reg    <= click_count_next;
        end
    end

    `BCC_ASSERT_NEXT(a_event_restarts, aclk, aresetn,
        beat_en && event_code != bcc_pkg::EV_NONE,
        elapsed_ticks_reg == '0 && click_count_reg == bcc_pkg::CLICKS_NONE)
    `BCC_ASSERT_NEXT(a_edge_restarts, aclk, aresetn, beat_en && level_edge,
        elapsed_ticks_reg == '0 && prior_level_reg == $past(level))
    `BCC_ASSERT_NEXT(a_count_monotonic, aclk, aresetn, beat_en,
        click_count_reg >= $past(click_count_reg) || click_count_reg == bcc_pkg::CLICKS_NONE)

endmodule
`default_nettype wire

// File: sv/button_click_classifier.sv
// Button click classifier: single, double and long press detection for one button.
//
// Usage:
//   s_valid/s_ready/s_level carry one timer tick per beat with the sampled
//   button level (0 pressed, 1 released). Every accepted tick yields exactly
//   one result beat on m_valid/m_ready/m_event_code: 0 none, 1 single click,
//   2 double click, 3 long press.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write release_limit (0), min_press
//   (1) and max_press (2); cfg_ready is always high, other indexes are dropped.
//   Write configuration only while no ticks are in flight.
//   Output: the result of a tick is registered and on m_* in the cycle after it is accepted.
//   Throughput: one tick per cycle while m_ready is high, set by the combinational
//   state update between the state registers and the output register.
//   Stall: while a result waits with m_ready low, s_ready is low; a result
//   taken in the same cycle frees the slot for the next tick.
//   Reset (aresetn low, synchronous): registers return to 3000/200/10000,
//   the button is taken as released, timers and click count clear and no
//   result is pending.
`default_nettype none
`include "button_click_classifier_defines.svh"
module button_click_classifier #(
    parameter int TIMER_BITS = 16
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_level,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [1:0]                         m_event_code,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [bcc_pkg::CFG_W-1:0]     cfg_data
);

    bcc_pkg::cfg_t        cfg;
    bcc_pkg::event_code_t core_event;
    logic                 in_fire;

    logic                 m_valid_reg, m_valid_next;
    bcc_pkg::event_code_t m_event_code_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;

    bcc_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bcc_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat_en    (in_fire),
        .level      (s_level),
        .cfg        (cfg),
        .event_code (core_event)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (in_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            m_event_code_reg <= core_event;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_code = m_event_code_reg;

    `BCC_ASSERT_SAME(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `BCC_ASSERT_NEXT(a_beat_yields_result, aclk, aresetn, in_fire, m_valid)
    `BCC_ASSERT_NEXT(a_result_clears, aclk, aresetn, m_valid && m_ready && !s_valid, !m_valid)

endmodule
`default_nettype wire
